[hw/rtl/indexed_framebuffer_pixel_engine_defines.svh]
// Assertion macros used by the pixel engine top level.
`ifndef INDEXED_FRAMEBUFFER_PIXEL_ENGINE_DEFINES_SVH
`define INDEXED_FRAMEBUFFER_PIXEL_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define IFPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define IFPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ifpe_pkg.sv]
// Types and constants of the indexed frame buffer pixel engine.
package ifpe_pkg;

  // Request kinds carried on req_type.
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_PAL   = 2'd2,
    REQ_FILL  = 2'd3
  } req_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_ROTATION = 2'd2;

  // Quarter-turn codes of the rotation register.
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Register values after reset.
  localparam int RESET_WIDTH  = 320;
  localparam int RESET_HEIGHT = 240;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_ADDR,
    ST_WRITE,
    ST_FREAD,
    ST_PREAD,
    ST_RDONE,
    ST_PALW,
    ST_FILL
  } state_t;

  // Palette write request.
  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    logic [15:0] rgb;
  } pal_wr_t;

endpackage

[hw/rtl/ifpe_palette.sv]
// Palette memory with per-entry valid bits so that unwritten entries read as zero.
module ifpe_palette #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  ifpe_pkg::pal_wr_t wr,
  input  logic [7:0]       rd_idx,
  output logic [15:0]      rd_color
);

  localparam int PW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [15:0]                mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] valid;
  logic                       wr_ok;
  logic                       rd_ok;
  logic                       hit;
  logic [15:0]                rd_data;

  // Indexes beyond the palette are ignored on write and read as zero.
  assign wr_ok = wr.en && (32'(wr.idx) < PALETTE_ENTRIES);
  assign rd_ok = 32'(rd_idx) < PALETTE_ENTRIES;

  // Storage array and registered read port.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.idx[PW-1:0]] <= wr.rgb;
    end
    rd_data <= mem[rd_idx[PW-1:0]];
  end

  // Valid bits stand in for clearing the palette at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit   <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid[wr.idx[PW-1:0]] <= 1'b1;
      end
      hit <= rd_ok && valid[rd_idx[PW-1:0]];
    end
  end

  assign rd_color = hit ? rd_data : 16'd0;

endmodule

[hw/rtl/indexed_framebuffer_pixel_engine.sv]
// Top level of the palette-indexed frame buffer pixel engine.
//
// A request is taken when start is high and busy is low; busy stays high until the
// request has finished. Each request gives one result, shown for exactly one cycle
// with done high: read_color and in_bounds, plus the dirty box on dirty_* (which
// holds its value between results). The receiver cannot stall the block.
// A pixel read steps through the address multiply, then the frame memory read, then
// the palette memory read, and so takes longer than a pixel or palette write.
// A fill writes one frame entry per cycle over all MAX_WIDTH*MAX_HEIGHT entries, its
// pace set by the single write port of the frame memory.
// Only one request is in flight at a time. The next request can be taken in the
// cycle that shows the previous result.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is high whenever no request is in progress.
// Reset clears the palette (through valid bits), sets width 320, height 240,
// rotation 0 and an empty dirty box. The frame memory is not cleared and must be
// written before it is read.
module indexed_framebuffer_pixel_engine #(
  parameter int MAX_WIDTH       = 320,
  parameter int MAX_HEIGHT      = 240,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [7:0]         color_index,
  input  logic [15:0]        rgb_value,
  output logic               done,
  output logic [15:0]        read_color,
  output logic               in_bounds,
  output logic [8:0]         dirty_min_x,
  output logic [8:0]         dirty_max_x,
  output logic [7:0]         dirty_min_y,
  output logic [7:0]         dirty_max_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  `include "indexed_framebuffer_pixel_engine_defines.svh"

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = (AW > 18) ? AW : 18;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam int RST_EFF_W = (MAX_WIDTH < ifpe_pkg::RESET_WIDTH) ?
                             MAX_WIDTH : ifpe_pkg::RESET_WIDTH;
  localparam int RST_EFF_H = (MAX_HEIGHT < ifpe_pkg::RESET_HEIGHT) ?
                             MAX_HEIGHT : ifpe_pkg::RESET_HEIGHT;

  ifpe_pkg::state_t state, state_next;

  // Configuration registers.
  logic [8:0] frame_width;
  logic [7:0] frame_height;
  logic [1:0] rotation;

  // Request registers.
  ifpe_pkg::req_t      req_kind;
  logic signed [15:0]  px;
  logic signed [15:0]  py;
  logic [7:0]          cidx;
  logic [15:0]         rgb;

  // Address computation registers.
  logic          inb;
  logic [8:0]    rx;
  logic [7:0]    ry;
  logic [AW-1:0] addr;
  logic [AW-1:0] fill_cnt;

  // Frame memory.
  logic [7:0]    frame_mem [DEPTH];
  logic [7:0]    frame_q;
  logic          frame_we;
  logic [AW-1:0] frame_addr;

  // Palette ports.
  ifpe_pkg::pal_wr_t pal_wr;
  logic [15:0]       pal_color;

  // Sequencer outputs.
  logic        finish;
  logic [15:0] fin_color;
  logic        fin_inb;
  logic        box_write;
  logic        box_fill;
  logic        fill_step;

  // Geometry.
  logic [8:0]         eff_w;
  logic [7:0]         eff_h;
  logic signed [17:0] xe, ye, wm1, hm1, rxs, rys;
  logic               clip_ok;
  logic [PROD_W-1:0]  pos_full;

  // Effective frame size, saturated to 1..MAX.
  always_comb begin
    if (frame_width == 9'd0) begin
      eff_w = 9'd1;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = 9'(MAX_WIDTH);
    end else begin
      eff_w = frame_width;
    end
    if (frame_height == 8'd0) begin
      eff_h = 8'd1;
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = 8'(MAX_HEIGHT);
    end else begin
      eff_h = frame_height;
    end
  end

  // Rotation of write coordinates and clipping against the frame.
  always_comb begin
    xe  = {{2{px[15]}}, px};
    ye  = {{2{py[15]}}, py};
    wm1 = $signed({9'd0, eff_w}) - 18'sd1;
    hm1 = $signed({10'd0, eff_h}) - 18'sd1;
    rxs = xe;
    rys = ye;
    if (req_kind == ifpe_pkg::REQ_WRITE) begin
      case (rotation)
        ifpe_pkg::ROT_90: begin
          rxs = wm1 - ye;
          rys = xe;
        end
        ifpe_pkg::ROT_180: begin
          rxs = wm1 - xe;
          rys = hm1 - ye;
        end
        ifpe_pkg::ROT_270: begin
          rxs = ye;
          rys = hm1 - xe;
        end
        default: begin
          rxs = xe;
          rys = ye;
        end
      endcase
    end
    clip_ok = (rxs >= 18'sd0) && (rxs <= wm1) && (rys >= 18'sd0) && (rys <= hm1);
  end

  // Linear frame address of the clipped point.
  assign pos_full = PROD_W'(ry) * PROD_W'(eff_w) + PROD_W'(rx);

  // Next state and per-state controls.
  always_comb begin
    state_next = state;
    frame_we   = 1'b0;
    frame_addr = addr;
    pal_wr     = '0;
    finish     = 1'b0;
    fin_color  = 16'd0;
    fin_inb    = 1'b0;
    box_write  = 1'b0;
    box_fill   = 1'b0;
    fill_step  = 1'b0;
    case (state)
      ifpe_pkg::ST_IDLE: begin
        if (start) begin
          state_next = ifpe_pkg::ST_CALC;
        end
      end
      ifpe_pkg::ST_CALC: begin
        state_next = ifpe_pkg::ST_ADDR;
      end
      ifpe_pkg::ST_ADDR: begin
        case (req_kind)
          ifpe_pkg::REQ_WRITE: state_next = ifpe_pkg::ST_WRITE;
          ifpe_pkg::REQ_READ:  state_next = ifpe_pkg::ST_FREAD;
          ifpe_pkg::REQ_PAL:   state_next = ifpe_pkg::ST_PALW;
          default:             state_next = ifpe_pkg::ST_FILL;
        endcase
      end
      ifpe_pkg::ST_WRITE: begin
        frame_we   = inb;
        box_write  = inb;
        finish     = 1'b1;
        fin_inb    = inb;
        state_next = ifpe_pkg::ST_IDLE;
      end
      ifpe_pkg::ST_FREAD: begin
        state_next = ifpe_pkg::ST_PREAD;
      end
      ifpe_pkg::ST_PREAD: begin
        state_next = ifpe_pkg::ST_RDONE;
      end
      ifpe_pkg::ST_RDONE: begin
        finish     = 1'b1;
        fin_inb    = inb;
        fin_color  = inb ? pal_color : 16'd0;
        state_next = ifpe_pkg::ST_IDLE;
      end
      ifpe_pkg::ST_PALW: begin
        pal_wr.en  = 1'b1;
        pal_wr.idx = cidx;
        pal_wr.rgb = rgb;
        finish     = 1'b1;
        state_next = ifpe_pkg::ST_IDLE;
      end
      ifpe_pkg::ST_FILL: begin
        frame_addr = fill_cnt;
        frame_we   = 1'b1;
        if (fill_cnt == LAST_ADDR) begin
          box_fill   = 1'b1;
          finish     = 1'b1;
          state_next = ifpe_pkg::ST_IDLE;
        end else begin
          fill_step = 1'b1;
        end
      end
      default: begin
        state_next = ifpe_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ifpe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy      = (state != ifpe_pkg::ST_IDLE);
  assign cfg_ready = !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 9'(ifpe_pkg::RESET_WIDTH);
      frame_height <= 8'(ifpe_pkg::RESET_HEIGHT);
      rotation     <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ifpe_pkg::REG_WIDTH:    frame_width  <= cfg_data;
        ifpe_pkg::REG_HEIGHT:   frame_height <= cfg_data[7:0];
        ifpe_pkg::REG_ROTATION: rotation     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Request capture and address pipeline.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_kind <= ifpe_pkg::req_t'(req_type);
      px       <= pos_x;
      py       <= pos_y;
      cidx     <= color_index;
      rgb      <= rgb_value;
      fill_cnt <= '0;
    end else if (fill_step) begin
      fill_cnt <= fill_cnt + AW'(1);
    end
    if (state == ifpe_pkg::ST_CALC) begin
      inb <= clip_ok;
      rx  <= rxs[8:0];
      ry  <= rys[7:0];
    end
    if (state == ifpe_pkg::ST_ADDR) begin
      addr <= pos_full[AW-1:0];
    end
  end

  // Frame memory with one registered read port.
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_addr] <= cidx;
    end
    frame_q <= frame_mem[frame_addr];
  end

  ifpe_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk      (clk),
    .rst      (rst),
    .wr       (pal_wr),
    .rd_idx   (frame_q),
    .rd_color (pal_color)
  );

  // Dirty bounding box.
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty_min_x <= 9'(RST_EFF_W);
      dirty_max_x <= 9'd0;
      dirty_min_y <= 8'(RST_EFF_H);
      dirty_max_y <= 8'd0;
    end else if (box_fill) begin
      dirty_min_x <= 9'd0;
      dirty_max_x <= eff_w - 9'd1;
      dirty_min_y <= 8'd0;
      dirty_max_y <= eff_h - 8'd1;
    end else if (box_write) begin
      if (rx < dirty_min_x) dirty_min_x <= rx;
      if (rx > dirty_max_x) dirty_max_x <= rx;
      if (ry < dirty_min_y) dirty_min_y <= ry;
      if (ry > dirty_max_y) dirty_max_y <= ry;
    end
  end

  // Result strobe and result fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
    if (finish) begin
      read_color <= fin_color;
      in_bounds  <= fin_inb;
    end
  end

  // Checks on the sequencer and result fields.
  `IFPE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `IFPE_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
  `IFPE_ASSERT_NOW(a_off_zero, done && !in_bounds, read_color == 16'd0,
                   "off-screen result carries a colour")
  `IFPE_ASSERT_NOW(a_cfg_blocked, busy, !cfg_ready, "configuration open during a request")

endmodule

[dv/testbench.sv]
// Self-checking testbench of the indexed frame buffer pixel engine.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ifpe_pkg::*;

  localparam int FB_MAX_W    = 320;
  localparam int FB_MAX_H    = 240;
  localparam int PAL_SIZE    = 256;
  localparam int FB_DEPTH    = FB_MAX_W * FB_MAX_H;
  localparam int CYCLE_LIMIT = 2_000_000;
  // Register index with no register behind it; a write there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // One result of the block as it should appear on the result ports.
  typedef struct packed {
    logic [15:0] color;
    logic        inb;
    logic [8:0]  min_x;
    logic [8:0]  max_x;
    logic [7:0]  min_y;
    logic [7:0]  max_y;
  } pixel_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         req_type;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0]         color_index;
  logic [15:0]        rgb_value;
  logic               done;
  logic [15:0]        read_color;
  logic               in_bounds;
  logic [8:0]         dirty_min_x;
  logic [8:0]         dirty_max_x;
  logic [7:0]         dirty_min_y;
  logic [7:0]         dirty_max_y;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [8:0]         cfg_data;

  // Shadow copy of the block's state, kept in step with accepted requests.
  logic [15:0] palette_shadow [PAL_SIZE];
  logic [7:0]  frame_shadow [FB_DEPTH];
  bit          pixel_written [FB_DEPTH];
  logic [8:0]  width_reg;
  logic [7:0]  height_reg;
  logic [1:0]  rotation_reg;
  int          box_min_x;
  int          box_max_x;
  int          box_min_y;
  int          box_max_y;
  int          last_written_pos;
  int          fills_done;

  pixel_result_t pending_results [$];
  int            failures = 0;
  int            cycle_count = 0;

  indexed_framebuffer_pixel_engine #(
    .MAX_WIDTH(FB_MAX_W),
    .MAX_HEIGHT(FB_MAX_H),
    .PALETTE_ENTRIES(PAL_SIZE)
  ) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up if the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > FB_MAX_W) return FB_MAX_W;
    return width_reg;
  endfunction

  function automatic int active_height();
    if (height_reg == 0) return 1;
    if (height_reg > FB_MAX_H) return FB_MAX_H;
    return height_reg;
  endfunction

  function automatic bit on_screen(int x, int y, int w, int h);
    return x >= 0 && x < w && y >= 0 && y < h;
  endfunction

  // Unrotated coordinates of the most recent stored pixel under the present frame size.
  function automatic bit last_write_point(output int x, output int y);
    int w;
    w = active_width();
    if (last_written_pos < 0 || last_written_pos >= w * active_height()) return 1'b0;
    x = last_written_pos % w;
    y = last_written_pos / w;
    return 1'b1;
  endfunction

  function automatic void reset_shadow();
    foreach (palette_shadow[i]) palette_shadow[i] = '0;
    foreach (pixel_written[i]) pixel_written[i] = 1'b0;
    width_reg        = 9'(RESET_WIDTH);
    height_reg       = 8'(RESET_HEIGHT);
    rotation_reg     = 2'd0;
    box_min_x        = RESET_WIDTH;
    box_min_y        = RESET_HEIGHT;
    box_max_x        = 0;
    box_max_y        = 0;
    last_written_pos = -1;
    fills_done       = 0;
  endfunction

  // Applies one request to the shadow state and returns the result it should give.
  function automatic pixel_result_t predict_pixel_result(req_t kind, int x, int y,
                                                         logic [7:0] ci, logic [15:0] rgb);
    int w;
    int h;
    int t;
    int pos;
    pixel_result_t r;
    w = active_width();
    h = active_height();
    r.color = '0;
    r.inb   = 1'b0;
    case (kind)
      REQ_WRITE: begin
        // Quarter turns use the far edges width-1 and height-1.
        case (rotation_reg)
          ROT_90: begin
            t = x;
            x = (w - 1) - y;
            y = t;
          end
          ROT_180: begin
            x = (w - 1) - x;
            y = (h - 1) - y;
          end
          ROT_270: begin
            t = x;
            x = y;
            y = (h - 1) - t;
          end
          default: ;
        endcase
        if (on_screen(x, y, w, h)) begin
          pos                = y * w + x;
          r.inb              = 1'b1;
          frame_shadow[pos]  = ci;
          pixel_written[pos] = 1'b1;
          last_written_pos   = pos;
          if (x < box_min_x) box_min_x = x;
          if (x > box_max_x) box_max_x = x;
          if (y < box_min_y) box_min_y = y;
          if (y > box_max_y) box_max_y = y;
        end
      end
      REQ_READ: begin
        if (on_screen(x, y, w, h)) begin
          r.inb   = 1'b1;
          r.color = palette_shadow[frame_shadow[y * w + x]];
        end
      end
      REQ_PAL: begin
        if (ci < PAL_SIZE) palette_shadow[ci] = rgb;
      end
      default: begin
        // A fill covers the whole store, beyond the present frame size too.
        foreach (frame_shadow[i]) frame_shadow[i] = ci;
        foreach (pixel_written[i]) pixel_written[i] = 1'b1;
        box_min_x = 0;
        box_min_y = 0;
        box_max_x = w - 1;
        box_max_y = h - 1;
        fills_done++;
      end
    endcase
    r.min_x = box_min_x[8:0];
    r.max_x = box_max_x[8:0];
    r.min_y = box_min_y[7:0];
    r.max_y = box_max_y[7:0];
    return r;
  endfunction

  // Sends one request, after an optional idle gap, and records what it should give.
  // Start stays high afterwards so that the next request can follow at once.
  task automatic send_request(req_t kind, logic signed [15:0] x, logic signed [15:0] y,
                              logic [7:0] ci, logic [15:0] rgb, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= kind;
    pos_x       <= x;
    pos_y       <= y;
    color_index <= ci;
    rgb_value   <= rgb;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_pixel_result(kind, x, y, ci, rgb));
  endtask

  // Holds requests back until every outstanding result has come.
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One register write; the block must be idle.
  task automatic write_register(logic [1:0] idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:    width_reg = data;
      REG_HEIGHT:   height_reg = data[7:0];
      REG_ROTATION: rotation_reg = data[1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [8:0] w, logic [8:0] h, logic [8:0] rot);
    wait_for_results();
    write_register(REG_WIDTH, w);
    write_register(REG_HEIGHT, h);
    write_register(REG_ROTATION, rot);
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // Each strobed result is matched against the oldest outstanding request.
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("Result with no request outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        compare_field("read_color", want.color, read_color);
        compare_field("in_bounds", 16'(want.inb), 16'(in_bounds));
        compare_field("dirty_min_x", 16'(want.min_x), 16'(dirty_min_x));
        compare_field("dirty_max_x", 16'(want.max_x), 16'(dirty_max_x));
        compare_field("dirty_min_y", 16'(want.min_y), 16'(dirty_min_y));
        compare_field("dirty_max_y", 16'(want.max_y), 16'(dirty_max_y));
      end
    end
  end

  // Reset values of the dirty box, then a box grown by plain writes.
  task automatic test_reset_state();
    send_request(REQ_PAL, 16'sd0, 16'sd0, 8'hFF, 16'hFFFF, 0);
    send_request(REQ_PAL, 16'sd0, 16'sd0, 8'h01, 16'h07E0, 0);
    send_request(REQ_WRITE, 16'sd5, 16'sd7, 8'h01, 16'h0000, 0);
    send_request(REQ_WRITE, 16'sd2, 16'sd9, 8'hFF, 16'hFFFF, 0);
    send_request(REQ_WRITE, -16'sd32768, 16'sd32767, 8'h00, 16'h0000, 0);
    send_request(REQ_WRITE, 16'sd32767, -16'sd32768, 8'h00, 16'h0000, 0);
    send_request(REQ_READ, 16'sd5, 16'sd7, 8'h00, 16'h0000, 0);
    send_request(REQ_READ, 16'sd2, 16'sd9, 8'hFF, 16'hFFFF, 0);
    send_request(REQ_READ, 16'sd320, 16'sd0, 8'h00, 16'h0000, 0);
  endtask

  // Each quarter turn, read back at the unrotated position it landed on.
  task automatic test_rotation();
    int x;
    int y;
    for (int rot = 1; rot < 4; rot++) begin
      configure(9'(RESET_WIDTH), 9'(RESET_HEIGHT), 9'(rot));
      send_request(REQ_WRITE, 16'sd10, 16'sd3, 8'(rot), 16'h0000, 0);
      if (last_write_point(x, y)) send_request(REQ_READ, 16'(x), 16'(y), 8'h00, 16'h0000, 0);
    end
    send_request(REQ_WRITE, 16'sd0, -16'sd32768, 8'h55, 16'h0000, 0);
  endtask

  // Out-of-range sizes saturate, and the spare register index changes nothing.
  task automatic test_size_registers();
    configure(9'h000, 9'h000, 9'h000);
    send_request(REQ_WRITE, 16'sd0, 16'sd0, 8'hFF, 16'h0000, 0);
    send_request(REQ_WRITE, 16'sd1, 16'sd0, 8'h01, 16'h0000, 0);
    send_request(REQ_READ, 16'sd0, 16'sd0, 8'h00, 16'h0000, 0);
    configure(9'h1FF, 9'h1FF, 9'h1FC);
    send_request(REQ_WRITE, 16'sd319, 16'sd239, 8'h01, 16'h0000, 0);
    send_request(REQ_WRITE, 16'sd320, 16'sd239, 8'h01, 16'h0000, 0);
    wait_for_results();
    write_register(REG_SPARE, 9'h155);
    send_request(REQ_READ, 16'sd319, 16'sd239, 8'h00, 16'h0000, 0);
  endtask

  // A fill on a small frame still sets pixels outside it.
  task automatic test_fill_beyond_frame();
    configure(9'd10, 9'd10, 9'd0);
    send_request(REQ_PAL, 16'sd0, 16'sd0, 8'hA5, 16'h1234, 0);
    send_request(REQ_FILL, 16'sd0, 16'sd0, 8'hA5, 16'h0000, 0);
    configure(9'(RESET_WIDTH), 9'(RESET_HEIGHT), 9'd0);
    send_request(REQ_READ, 16'sd319, 16'sd239, 8'h00, 16'h0000, 0);
  endtask

  function automatic logic [8:0] random_size(int full);
    case ($urandom_range(0, 5))
      0:       return 9'(full);
      1:       return 9'($urandom_range(1, 8));
      2:       return 9'($urandom_range(0, 511));
      default: return 9'($urandom_range(1, full));
    endcase
  endfunction

  // Random requests under the present configuration. Coordinates mostly land
  // in or near the frame; some span the whole signed range.
  task automatic random_traffic(int count, bit fills_allowed, bit idle_allowed);
    req_t kind;
    int   w;
    int   h;
    int   span;
    int   x;
    int   y;
    int   pick;
    int   gap;
    for (int i = 0; i < count; i++) begin
      w    = active_width();
      h    = active_height();
      span = (w > h) ? w : h;
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = REQ_WRITE;
      else if (pick < 75) kind = REQ_READ;
      else kind = REQ_PAL;
      if (fills_allowed && fills_done < 4 && $urandom_range(0, 399) == 0) kind = REQ_FILL;
      case ($urandom_range(0, 9))
        0: begin
          x = int'($urandom_range(0, 65535)) - 32768;
          y = int'($urandom_range(0, 65535)) - 32768;
        end
        1, 2: begin
          x = int'($urandom_range(0, span + 1)) - 1;
          y = int'($urandom_range(0, span + 1)) - 1;
        end
        default: begin
          x = $urandom_range(0, span - 1);
          y = $urandom_range(0, span - 1);
        end
      endcase
      // Never read a pixel that has not been stored yet.
      if (kind == REQ_READ && on_screen(x, y, w, h) && !pixel_written[y * w + x]) begin
        if (!last_write_point(x, y)) x = -1;
      end
      gap = (idle_allowed && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      send_request(kind, 16'(x), 16'(y), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), gap);
      // Now and then let the block drain completely.
      if (idle_allowed && $urandom_range(0, 199) == 0) wait_for_results();
    end
  endtask

  // Before any fill the box minimum can still shrink, so run writes there first.
  task automatic test_random_sketch();
    for (int phase = 0; phase < 2; phase++) begin
      configure(random_size(FB_MAX_W), random_size(FB_MAX_H), 9'($urandom_range(0, 511)));
      random_traffic(100, 1'b0, 1'b1);
    end
  endtask

  // Main random run over many configurations; the closing phases never idle.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 0) configure(9'(FB_MAX_W), 9'(FB_MAX_H), 9'($urandom_range(0, 511)));
      else configure(random_size(FB_MAX_W), random_size(FB_MAX_H), 9'($urandom_range(0, 511)));
      random_traffic(125, 1'b1, phase < 9 && $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    req_type    <= REQ_WRITE;
    pos_x       <= '0;
    pos_y       <= '0;
    color_index <= '0;
    rgb_value   <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_WIDTH;
    cfg_data    <= '0;
    reset_shadow();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_rotation();
    test_size_registers();
    test_random_sketch();
    test_fill_beyond_frame();
    test_random_traffic();

    // Let the last results arrive, then watch for stray ones.
    wait_for_results();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ifpe_pkg.sv
hw/rtl/ifpe_palette.sv
hw/rtl/indexed_framebuffer_pixel_engine.sv
dv/testbench.sv
